[hw/rtl/bsrd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrd_pkg
// Shared types, codes and helpers for the baud sweep rate detector.
// ----------------------------------------------------------------------------
package bsrd_pkg;

    // Default parameter values
    localparam int NUM_RATES_DEF  = 8;
    localparam int COUNT_BITS_DEF = 20;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 3;
    localparam int OUTC_W  = 2;
    localparam int TICK_W  = 16;
    localparam int MINB_W  = 20;
    localparam int PCT_W   = 7;
    localparam int CFG_W   = 20;
    localparam int CFGI_W  = 2;
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE   = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

    // Outcome codes
    localparam logic [OUTC_W-1:0] OUTC_NEVER   = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_RUNNING = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_SUCCESS = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_FAILED  = 2'd3;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_WINDOW_TICKS  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MIN_BYTES     = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_MIN_RATIO_PCT = 2'd2;

    // Configuration reset values
    localparam logic [TICK_W-1:0] WINDOW_TICKS_RST  = 16'd350;
    localparam logic [MINB_W-1:0] MIN_BYTES_RST     = 20'd8;
    localparam logic [PCT_W-1:0]  MIN_RATIO_PCT_RST = 7'd70;

    // Readable character set
    localparam logic [BYTE_W-1:0] CHR_LO  = 8'd32;
    localparam logic [BYTE_W-1:0] CHR_HI  = 8'd126;
    localparam logic [BYTE_W-1:0] CHR_CR  = 8'd13;
    localparam logic [BYTE_W-1:0] CHR_LF  = 8'd10;
    localparam logic [BYTE_W-1:0] CHR_TAB = 8'd9;
    localparam int PCT_SCALE = 100;

    typedef logic [OP_W-1:0] t_opcode;

    // One input word as held in the input register
    typedef struct packed {
        t_opcode             op;
        logic [BYTE_W-1:0]   rx_byte;
    } t_in_word;

    function automatic logic printable_char(input logic [BYTE_W-1:0] b);
        printable_char = b inside {[CHR_LO:CHR_HI], CHR_CR, CHR_LF, CHR_TAB};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/bsrd_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrd_in_stage
// Input word register; refills in the same cycle the held word is consumed.
// ----------------------------------------------------------------------------
module bsrd_in_stage
    import bsrd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_word,
    input  wire logic     i_consume,
    output logic          o_valid,
    output t_in_word      o_word
);

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/bsrd_qualify.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrd_qualify
// Window scoring: byte floor, readable ratio and better-than-best checks.
// ----------------------------------------------------------------------------
module bsrd_qualify
    import bsrd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic [COUNT_BITS-1:0] i_bytes,
    input  wire logic [COUNT_BITS-1:0] i_readable,
    input  wire logic [COUNT_BITS-1:0] i_top_readable,
    input  wire logic [MINB_W-1:0]     i_min_bytes,
    input  wire logic [PCT_W-1:0]      i_min_ratio_pct,
    output logic                       o_qualifies
);

    localparam int CMP_W  = (COUNT_BITS > MINB_W) ? COUNT_BITS : MINB_W;
    localparam int PROD_W = COUNT_BITS + PCT_W;

    logic [PROD_W-1:0] w_read_scaled;
    logic [PROD_W-1:0] w_need_scaled;
    logic              w_enough;
    logic              w_ratio_ok;
    logic              w_better;

    // readable*100 vs pct*bytes replaces the percentage division
    assign w_read_scaled = PROD_W'(i_readable) * PROD_W'(PCT_SCALE);
    assign w_need_scaled = PROD_W'(i_min_ratio_pct) * PROD_W'(i_bytes);

    assign w_enough   = CMP_W'(i_bytes) >= CMP_W'(i_min_bytes);
    assign w_ratio_ok = w_read_scaled >= w_need_scaled;
    assign w_better   = i_readable > i_top_readable;

    assign o_qualifies = w_enough && w_ratio_ok && w_better;

endmodule
`default_nettype wire

[hw/rtl/baud_sweep_rate_detector_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baud_sweep_rate_detector_core
// Passive autobaud sweep: scores readable traffic per candidate rate index.
// ----------------------------------------------------------------------------
// Each input word (tuser = opcode, tdata = received byte) yields exactly one
// status word. The block accepts one word per clock and delivers one status
// word per clock while m_axis_tready stays high; a word passes an input
// register and then the result register, which drives the master side.
// The sustained rate is set by the combinational update of the sweep state
// (tick, byte and readable counters plus the window score) between the two
// registers. The input register refills in the same cycle it is drained, so
// while it holds a word s_axis_tready drops as soon as the output stalls.
// Start restarts the sweep at index 0 and asks the UART to retune; each
// closed window moves to the next index; after the last index the result
// reports success with the best index, or failure and a return to the live
// configured rate. Configuration writes belong to idle periods only.
// ----------------------------------------------------------------------------
module baud_sweep_rate_detector_core
    import bsrd_pkg::*;
#(
    parameter int NUM_RATES  = NUM_RATES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic [CFGI_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]    i_cfg_data,

    // input words
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte
    input  wire logic [S_USER_W-1:0] s_axis_tuser,  // [1:0] opcode, [7:2] unused

    // status words
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // [0] run_active, [2:1] outcome, [5:3] candidate_index, [6] reprogram,
    // [7] tune_live_rate, [10:8] tune_index, [11] best_valid,
    // [14:12] best_index, [15] zero
    output logic [M_DATA_W-1:0]      m_axis_tdata
);

    localparam int POS_W = IDX_W + 1;

    // ---------------- configuration registers ----------------
    logic [TICK_W-1:0] r_window_ticks;
    logic [MINB_W-1:0] r_min_bytes;
    logic [PCT_W-1:0]  r_min_ratio_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks  <= WINDOW_TICKS_RST;
            r_min_bytes     <= MIN_BYTES_RST;
            r_min_ratio_pct <= MIN_RATIO_PCT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_TICKS:  r_window_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_MIN_BYTES:     r_min_bytes     <= i_cfg_data[MINB_W-1:0];
                CFG_MIN_RATIO_PCT: r_min_ratio_pct <= i_cfg_data[PCT_W-1:0];
                default: ;  // unmapped index: dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    t_in_word w_in_word;
    t_in_word w_held;
    logic     w_held_valid;
    logic     w_adv;

    assign w_in_word.op      = s_axis_tuser[OP_W-1:0];
    assign w_in_word.rx_byte = s_axis_tdata[BYTE_W-1:0];

    bsrd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_word    (w_in_word),
        .i_consume (w_adv),
        .o_valid   (w_held_valid),
        .o_word    (w_held)
    );

    // ---------------- sweep state ----------------
    logic                  r_running,    n_running;
    logic [OUTC_W-1:0]     r_outcome,    n_outcome;
    logic [IDX_W-1:0]      r_pos,        n_pos;
    logic [TICK_W-1:0]     r_elapsed,    n_elapsed;
    logic [COUNT_BITS-1:0] r_bytes,      n_bytes;
    logic [COUNT_BITS-1:0] r_readable,   n_readable;
    logic [COUNT_BITS-1:0] r_top_readable, n_top_readable;
    logic [IDX_W-1:0]      r_best_pos,   n_best_pos;
    logic                  r_best_found, n_best_found;

    logic                  w_reprogram;
    logic                  w_tune_live;
    logic [IDX_W-1:0]      w_tune_idx;
    logic                  w_qualifies;
    logic [TICK_W-1:0]     w_tick_inc;
    logic [POS_W-1:0]      w_pos_inc;

    bsrd_qualify #(
        .COUNT_BITS (COUNT_BITS)
    ) u_qualify (
        .i_bytes         (r_bytes),
        .i_readable      (r_readable),
        .i_top_readable  (r_top_readable),
        .i_min_bytes     (r_min_bytes),
        .i_min_ratio_pct (r_min_ratio_pct),
        .o_qualifies     (w_qualifies)
    );

    // saturating tick count; window closes once it reaches window_ticks
    assign w_tick_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + TICK_W'(1);
    assign w_pos_inc  = POS_W'(r_pos) + POS_W'(1);

    always_comb begin
        n_running      = r_running;
        n_outcome      = r_outcome;
        n_pos          = r_pos;
        n_elapsed      = r_elapsed;
        n_bytes        = r_bytes;
        n_readable     = r_readable;
        n_top_readable = r_top_readable;
        n_best_pos     = r_best_pos;
        n_best_found   = r_best_found;
        w_reprogram    = 1'b0;
        w_tune_live    = 1'b0;
        w_tune_idx     = '0;

        case (w_held.op)
            OP_START: begin
                // restart from index 0 even mid-sweep
                n_running      = 1'b1;
                n_outcome      = OUTC_RUNNING;
                n_top_readable = '0;
                n_best_pos     = '0;
                n_best_found   = 1'b0;
                n_pos          = '0;
                n_elapsed      = '0;
                n_bytes        = '0;
                n_readable     = '0;
                w_reprogram    = 1'b1;
            end
            OP_BYTE: begin
                if (r_running) begin
                    if (r_bytes != '1) begin
                        n_bytes = r_bytes + COUNT_BITS'(1);
                    end
                    if (printable_char(w_held.rx_byte) && (r_readable != '1)) begin
                        n_readable = r_readable + COUNT_BITS'(1);
                    end
                end
            end
            OP_TICK: begin
                if (r_running) begin
                    n_elapsed = w_tick_inc;
                    if (w_tick_inc >= r_window_ticks) begin
                        if (w_qualifies) begin
                            n_top_readable = r_readable;
                            n_best_pos     = r_pos;
                            n_best_found   = 1'b1;
                        end
                        w_reprogram = 1'b1;
                        if (w_pos_inc >= POS_W'(NUM_RATES)) begin
                            // last window closed: report and stop
                            n_running = 1'b0;
                            if (r_best_found || w_qualifies) begin
                                n_outcome  = OUTC_SUCCESS;
                                w_tune_idx = w_qualifies ? r_pos : r_best_pos;
                            end else begin
                                n_outcome   = OUTC_FAILED;
                                w_tune_live = 1'b1;
                            end
                        end else begin
                            n_pos      = w_pos_inc[IDX_W-1:0];
                            n_elapsed  = '0;
                            n_bytes    = '0;
                            n_readable = '0;
                            w_tune_idx = w_pos_inc[IDX_W-1:0];
                        end
                    end
                end
            end
            OP_CANCEL: begin
                // outcome stays as it was
                if (r_running) begin
                    n_running   = 1'b0;
                    w_reprogram = 1'b1;
                    w_tune_live = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // a held word steps the state when the result register can take it
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_DATA_W-1:0] n_out_data;

    assign w_adv = w_held_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_outcome      <= OUTC_NEVER;
            r_pos          <= '0;
            r_elapsed      <= '0;
            r_bytes        <= '0;
            r_readable     <= '0;
            r_top_readable <= '0;
            r_best_pos     <= '0;
            r_best_found   <= 1'b0;
        end else if (w_adv) begin
            r_running      <= n_running;
            r_outcome      <= n_outcome;
            r_pos          <= n_pos;
            r_elapsed      <= n_elapsed;
            r_bytes        <= n_bytes;
            r_readable     <= n_readable;
            r_top_readable <= n_top_readable;
            r_best_pos     <= n_best_pos;
            r_best_found   <= n_best_found;
        end
    end

    // ---------------- result register ----------------
    assign n_out_data = {1'b0, n_best_pos, n_best_found, w_tune_idx, w_tune_live,
                         w_reprogram, n_pos, n_outcome, n_running};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

[hw/rtl/bsrd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrd_checker
// Port-level checks on the status stream of the sweep detector.
// ----------------------------------------------------------------------------
module bsrd_checker
    import bsrd_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [M_DATA_W-1:0] m_axis_tdata
);

    // no status word straight out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("status valid right after reset");

    // stalled status word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled status word changed");

    // tune fields are zero unless a retune is requested
    a_tune_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> !m_axis_tdata[7] && m_axis_tdata[10:8] == 3'd0)
        else $error("tune fields set without reprogram");

    // a running sweep reports the running outcome
    a_run_outc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == OUTC_RUNNING)
        else $error("running without running outcome");

    // live-rate retune only when the sweep has stopped, with index zero
    a_live_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> !m_axis_tdata[0] && m_axis_tdata[10:8] == 3'd0)
        else $error("live retune while running or with index");

endmodule

bind baud_sweep_rate_detector_core bsrd_checker u_bsrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
